### src/cdwa_pkg.sv
package cdwa_pkg;

    // Default configuration of the averaging unit
    localparam int HISTORY_SIZE_D = 64;
    localparam int BLOCK_LEN_D    = 2;
    localparam int DISPLAY_RATE_D = 10;
    localparam int MAX_SECONDS_D  = 6;

    // Fixed field widths
    localparam int CLIMB_W = 24;
    localparam int CFG_W   = 3;
    localparam int RING_W  = 16;

    // Saturation bounds of a stored block mean
    localparam int SAT_LOW  = -32768;
    localparam int SAT_HIGH = 32767;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLK_GO,
        S_BLK_DIV,
        S_DISP,
        S_SUM,
        S_DSP_GO,
        S_DSP_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### src/climb_display_window_average_unit.sv
// With averaging off or the history empty, the sample passes straight through to the result.
// A completed block gets its mean from the divider (DW = divider width, 25 by default).
// A display average sums N ring entries, then divides (N = entries averaged, 60 at most).
// Throughput: one item at a time; the serial divider and the one-read-a-cycle ring walk set it.
// Reset (synchronous, active low): window off, block sum, counts, pointer and fill cleared.
module climb_display_window_average_unit #(
    parameter int HISTORY_SIZE = cdwa_pkg::HISTORY_SIZE_D,
    parameter int BLOCK_LEN    = cdwa_pkg::BLOCK_LEN_D,
    parameter int DISPLAY_RATE = cdwa_pkg::DISPLAY_RATE_D,
    parameter int MAX_SECONDS  = cdwa_pkg::MAX_SECONDS_D
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration
    input  logic                                     i_cfg_we,
    input  logic [cdwa_pkg::CFG_W-1:0]               i_cfg_wdata,
    // input channel
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic signed [cdwa_pkg::CLIMB_W-1:0]      i_climb_cms,
    input  logic                                     i_restart,
    // output channel
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [cdwa_pkg::CLIMB_W-1:0]      o_display_climb_cms,
    output logic [$clog2(HISTORY_SIZE+1)-1:0]        o_history_entries
);
    import cdwa_pkg::*;

    // Widths derived from the configuration
    localparam int AW   = $clog2(HISTORY_SIZE);            // ring address
    localparam int FW   = $clog2(HISTORY_SIZE + 1);        // fill count
    localparam int BCW  = $clog2(BLOCK_LEN + 1);           // block count
    localparam int BSW  = CLIMB_W + $clog2(BLOCK_LEN);     // block sum
    localparam int DSW  = RING_W + AW;                     // display sum
    localparam int DW   = (BSW > DSW) ? BSW : DSW;         // divider dividend
    localparam int DMAX = (BLOCK_LEN > HISTORY_SIZE) ? BLOCK_LEN : HISTORY_SIZE;
    localparam int VW   = $clog2(DMAX + 1);                // divider divisor
    localparam int WW   = CFG_W + $clog2(DISPLAY_RATE + 1); // wanted window length
    localparam int MW   = (WW > FW) ? WW : FW;

    // Control state
    t_state                  r_state, n_state;
    logic [CFG_W-1:0]        r_avg, n_avg;
    logic signed [BSW-1:0]   r_sum, n_sum;
    logic [BCW-1:0]          r_cnt, n_cnt;
    logic [AW-1:0]           r_wp, n_wp;
    logic [FW-1:0]           r_fill, n_fill;
    logic                    r_out_vld, n_out_vld;
    logic                    r_rd_vld, n_rd_vld;

    // Working registers
    logic signed [CLIMB_W-1:0] r_x, n_x;
    logic                      r_neg, n_neg;
    logic [FW-1:0]             r_n, n_n;
    logic [FW-1:0]             r_issue, n_issue;
    logic [AW-1:0]             r_raddr, n_raddr;
    logic signed [DSW-1:0]     r_acc, n_acc;
    logic signed [CLIMB_W-1:0] r_res, n_res;
    logic signed [CLIMB_W-1:0] r_out_disp, n_out_disp;
    logic [FW-1:0]             r_out_fill, n_out_fill;

    // History ring
    logic signed [RING_W-1:0]  r_ring [HISTORY_SIZE];
    logic signed [RING_W-1:0]  r_rd_data;
    logic                      ring_we;
    logic signed [RING_W-1:0]  ring_wdata;
    logic                      rd_en;

    // Shared divider
    logic                      div_start;
    logic [DW-1:0]             div_dividend;
    logic [VW-1:0]             div_divisor;
    t_div_stat                 div_stat;
    logic [DW-1:0]             div_quo;

    // Derived values
    logic signed [DW-1:0]      blk_ext;
    logic signed [DW-1:0]      dsp_ext;
    logic signed [DW:0]        quo_s;
    logic signed [DW:0]        mean_full;
    logic [WW-1:0]             want;
    logic                      in_xfer;
    logic                      out_xfer;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_out_vld && i_out_ready;
    assign blk_ext  = DW'(r_sum);
    assign dsp_ext  = DW'(r_acc);
    assign quo_s    = $signed({1'b0, div_quo});
    // Quotient is a magnitude; restore the dividend's sign (truncates toward zero)
    assign mean_full = r_neg ? -quo_s : quo_s;
    assign want      = WW'(r_avg) * WW'(DISPLAY_RATE);

    cdwa_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    always_comb begin
        logic signed [BSW-1:0] base_sum;
        logic [BCW-1:0]        cnt_inc;

        n_state    = r_state;
        n_avg      = r_avg;
        n_sum      = r_sum;
        n_cnt      = r_cnt;
        n_wp       = r_wp;
        n_fill     = r_fill;
        n_out_vld  = r_out_vld;
        n_rd_vld   = 1'b0;
        n_x        = r_x;
        n_neg      = r_neg;
        n_n        = r_n;
        n_issue    = r_issue;
        n_raddr    = r_raddr;
        n_acc      = r_acc;
        n_res      = r_res;
        n_out_disp = r_out_disp;
        n_out_fill = r_out_fill;

        o_in_ready   = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        ring_we      = 1'b0;
        ring_wdata   = '0;
        rd_en        = 1'b0;

        base_sum = i_restart ? '0 : r_sum;
        cnt_inc  = (i_restart ? '0 : r_cnt) + 1'b1;

        // Window setting: clamp to the longest allowed window
        if (i_cfg_we) begin
            n_avg = (int'(i_cfg_wdata) > MAX_SECONDS) ? CFG_W'(MAX_SECONDS) : i_cfg_wdata;
        end

        // Drop valid once the result transfers
        if (out_xfer) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_x   = i_climb_cms;
                    n_sum = base_sum + BSW'(i_climb_cms);
                    if (i_restart) begin
                        n_wp   = '0;
                        n_fill = '0;
                    end
                    if (cnt_inc == BCW'(BLOCK_LEN)) begin
                        n_cnt   = '0;
                        n_state = S_BLK_GO;
                    end else begin
                        n_cnt   = cnt_inc;
                        n_state = S_DISP;
                    end
                end
            end

            S_BLK_GO: begin
                // Divide the magnitude of the block sum by the block length
                div_start    = 1'b1;
                div_dividend = r_sum[BSW-1] ? DW'(-blk_ext) : DW'(blk_ext);
                div_divisor  = VW'(BLOCK_LEN);
                n_neg        = r_sum[BSW-1];
                n_state      = S_BLK_DIV;
            end

            S_BLK_DIV: begin
                if (div_stat.done) begin
                    // Saturate the block mean and store it at the write pointer
                    ring_we = 1'b1;
                    if (mean_full < (DW+1)'(SAT_LOW)) begin
                        ring_wdata = RING_W'(SAT_LOW);
                    end else if (mean_full > (DW+1)'(SAT_HIGH)) begin
                        ring_wdata = RING_W'(SAT_HIGH);
                    end else begin
                        ring_wdata = RING_W'(mean_full);
                    end
                    n_wp   = (r_wp == AW'(HISTORY_SIZE - 1)) ? '0 : r_wp + 1'b1;
                    n_fill = (r_fill == FW'(HISTORY_SIZE)) ? r_fill : r_fill + 1'b1;
                    n_sum  = '0;
                    n_state = S_DISP;
                end
            end

            S_DISP: begin
                if ((r_avg == '0) || (r_fill == '0)) begin
                    // Pass the sample through
                    n_res   = r_x;
                    n_state = S_DONE;
                end else begin
                    n_n     = (MW'(want) < MW'(r_fill)) ? FW'(want) : r_fill;
                    n_raddr = (r_wp == '0) ? AW'(HISTORY_SIZE - 1) : r_wp - 1'b1;
                    n_issue = '0;
                    n_acc   = '0;
                    n_state = S_SUM;
                end
            end

            S_SUM: begin
                // Walk back from the newest entry, one read a cycle
                if (r_issue != r_n) begin
                    rd_en    = 1'b1;
                    n_rd_vld = 1'b1;
                    n_issue  = r_issue + 1'b1;
                    n_raddr  = (r_raddr == '0) ? AW'(HISTORY_SIZE - 1) : r_raddr - 1'b1;
                end
                if (r_rd_vld) begin
                    n_acc = r_acc + DSW'(r_rd_data);
                end
                if ((r_issue == r_n) && !r_rd_vld) begin
                    n_state = S_DSP_GO;
                end
            end

            S_DSP_GO: begin
                div_start    = 1'b1;
                div_dividend = r_acc[DSW-1] ? DW'(-dsp_ext) : DW'(dsp_ext);
                div_divisor  = VW'(r_n);
                n_neg        = r_acc[DSW-1];
                n_state      = S_DSP_DIV;
            end

            S_DSP_DIV: begin
                if (div_stat.done) begin
                    n_res   = CLIMB_W'(mean_full);
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld  = 1'b1;
                    n_out_disp = r_res;
                    n_out_fill = r_fill;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_avg     <= '0;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_wp      <= '0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_avg     <= n_avg;
            r_sum     <= n_sum;
            r_cnt     <= n_cnt;
            r_wp      <= n_wp;
            r_fill    <= n_fill;
            r_out_vld <= n_out_vld;
            r_rd_vld  <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_neg      <= n_neg;
        r_n        <= n_n;
        r_issue    <= n_issue;
        r_raddr    <= n_raddr;
        r_acc      <= n_acc;
        r_res      <= n_res;
        r_out_disp <= n_out_disp;
        r_out_fill <= n_out_fill;
    end

    // Ring memory: entries past the fill count are never read, so no clear
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_wp] <= ring_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_ring[r_raddr];
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_display_climb_cms = r_out_disp;
    assign o_history_entries   = r_out_fill;

`ifndef ASSERT_OFF
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(HISTORY_SIZE))
        else $error("fill count above ring size");
    a_issue_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_issue <= r_n))
        else $error("ring walk read past the window");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("ready again right after a transfer");
    a_write_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_we |-> div_stat.done && (r_state == S_BLK_DIV))
        else $error("ring write outside a finished block divide");
    a_read_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(rd_en))
        else $error("read data flagged without a read");
`endif

endmodule

### src/cdwa_div.sv
module cdwa_div #(
    parameter int DW = 25,
    parameter int VW = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DW-1:0]       i_dividend,
    input  logic [VW-1:0]       i_divisor,
    output cdwa_pkg::t_div_stat o_stat,
    output logic [DW-1:0]       o_quotient
);
    import cdwa_pkg::*;

    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_div;
    logic [VW:0]   trial;
    logic          fits;

    // Restoring divide: one quotient bit per cycle, MSB first
    assign trial = {r_rem, r_quo[DW-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CW'(DW - 1);
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= fits ? VW'(trial - {1'b0, r_div}) : trial[VW-1:0];
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && !r_done)
        else $error("divider did not start");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("divider restarted while busy");
`endif

endmodule

### tb/sv/cdwa_display_check.sv
module cdwa_display_check (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_we,
    input  logic [cdwa_pkg::CFG_W-1:0]                    i_cfg_wdata,
    input  logic                                          i_in_valid,
    input  logic                                          i_in_ready,
    input  logic signed [cdwa_pkg::CLIMB_W-1:0]           i_climb_cms,
    input  logic                                          i_restart,
    input  logic                                          i_out_valid,
    input  logic                                          i_out_ready,
    input  logic signed [cdwa_pkg::CLIMB_W-1:0]           i_display_climb_cms,
    input  logic [$clog2(cdwa_pkg::HISTORY_SIZE_D+1)-1:0] i_history_entries,
    output int                                            o_errors,
    output int                                            o_pending,
    output int                                            o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import cdwa_pkg::*;

    localparam int ENTRY_W = $clog2(HISTORY_SIZE_D + 1);

    typedef struct packed {
        logic signed [CLIMB_W-1:0] display;
        logic [ENTRY_W-1:0]        entries;
    } t_display;

    t_display expected_displays[$];

    // Shadow of the unit's window register and averaging history
    int                       window_sec;
    longint                   blk_sum;
    int                       blk_cnt;
    logic signed [RING_W-1:0] hist [HISTORY_SIZE_D];
    int                       wr_ptr;
    int                       fill;

    int mismatch_count;
    int compared_count;
    int pending_count;

    assign o_errors  = mismatch_count;
    assign o_pending = pending_count;
    assign o_checked = compared_count;

    function automatic void clear_history();
        blk_sum = 0;
        blk_cnt = 0;
        wr_ptr  = 0;
        fill    = 0;
        foreach (hist[i]) hist[i] = '0;
    endfunction

    // Fold one sample into the history, then form the value shown for it
    function automatic t_display next_display(logic signed [CLIMB_W-1:0] climb, logic clear);
        t_display res;
        longint   mean;
        longint   acc;
        int       span;
        int       idx;
        if (clear) clear_history();
        blk_sum += longint'(climb);
        blk_cnt++;
        if (blk_cnt >= BLOCK_LEN_D) begin
            mean = blk_sum / longint'(blk_cnt);
            if (mean < longint'(SAT_LOW)) mean = longint'(SAT_LOW);
            if (mean > longint'(SAT_HIGH)) mean = longint'(SAT_HIGH);
            hist[wr_ptr] = RING_W'(mean);
            wr_ptr = (wr_ptr + 1) % HISTORY_SIZE_D;
            if (fill < HISTORY_SIZE_D) fill++;
            blk_sum = 0;
            blk_cnt = 0;
        end
        if (window_sec == 0 || fill == 0) begin
            res.display = climb;
        end else begin
            span = window_sec * DISPLAY_RATE_D;
            if (span > fill) span = fill;
            acc = 0;
            for (int i = 0; i < span; i++) begin
                idx = (wr_ptr + HISTORY_SIZE_D - 1 - i) % HISTORY_SIZE_D;
                acc += longint'(hist[idx]);
            end
            res.display = CLIMB_W'(acc / longint'(span));
        end
        res.entries = ENTRY_W'(fill);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_display want;
        if (!i_rst_n) begin
            window_sec = 0;
            clear_history();
            expected_displays.delete();
            pending_count  = 0;
            mismatch_count = 0;
            compared_count = 0;
        end else begin
            if (i_cfg_we) begin
                window_sec = (int'(i_cfg_wdata) > MAX_SECONDS_D) ? MAX_SECONDS_D
                                                                  : int'(i_cfg_wdata);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_displays.size() == 0) begin
                    $error("unexpected result: display_climb_cms %0d history_entries %0d",
                           i_display_climb_cms, i_history_entries);
                    mismatch_count++;
                end else begin
                    want = expected_displays.pop_front();
                    pending_count--;
                    compared_count++;
                    if (i_display_climb_cms !== want.display) begin
                        $error("display_climb_cms: expected %0d, actual %0d",
                               want.display, i_display_climb_cms);
                        mismatch_count++;
                    end
                    if (i_history_entries !== want.entries) begin
                        $error("history_entries: expected %0d, actual %0d",
                               want.entries, i_history_entries);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_displays.push_back(next_display(i_climb_cms, i_restart));
                pending_count++;
            end
        end
    end

endmodule

### tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdwa_pkg::*;

    localparam int ENTRY_W       = $clog2(HISTORY_SIZE_D + 1);
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_SAMPLES = 66;
    // Receiver hold-off long enough to back the unit up into its input
    localparam int HOLD_CYCLES   = 300;
    // Cycles to let the unit settle back to idle after its last transfer
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 200;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_W-1:0]          i_cfg_wdata;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic signed [CLIMB_W-1:0] i_climb_cms;
    logic                      i_restart;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [CLIMB_W-1:0] o_display_climb_cms;
    logic [ENTRY_W-1:0]        o_history_entries;

    int errors;
    int pending;
    int checked;

    // Stimulus bookkeeping for the closing summary
    int samples_sent;
    int restarts_sent;
    int window_writes;

    // Last phase runs without idling on either side
    bit quiet_phase;
    // Sender bumps the request count; receiver serves each one with a long hold-off
    int holdoff_requests;
    int holdoffs_served;

    int phase_windows[PHASE_COUNT] = '{1, 6, 3, 0, 5, 2, 4, 7};

    climb_display_window_average_unit uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_climb_cms         (i_climb_cms),
        .i_restart           (i_restart),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_display_climb_cms (o_display_climb_cms),
        .o_history_entries   (o_history_entries)
    );

    cdwa_display_check display_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_climb_cms         (i_climb_cms),
        .i_restart           (i_restart),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_display_climb_cms (o_display_climb_cms),
        .i_history_entries   (o_history_entries),
        .o_errors            (errors),
        .o_pending           (pending),
        .o_checked           (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("climb_display_window_average_unit verification failed");
        $finish;
    end

    // Result side: random ready bursts, plus a long hold-off on request.
    // Every change lands on a falling edge, one assignment per edge.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_requests != holdoffs_served) begin
                // hold ready low while the sender keeps offering; the unit must stall
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holdoffs_served++;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one sample and hold it until the unit takes it. An optional idle gap
    // with valid low comes first; valid is never dropped and raised on one edge.
    task automatic send_sample(input logic signed [CLIMB_W-1:0] climb, input logic clear);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_climb_cms <= climb;
        i_restart   <= clear;
        // the transfer happens at the first rising edge that sees ready high
        do @(posedge i_clk); while (!o_in_ready);
        samples_sent++;
        if (clear) restarts_sent++;
    endtask

    // Stop offering, wait for every predicted display value, then let the unit settle
    task automatic drain_unit();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Window register writes happen only with the unit idle
    task automatic write_window(input int seconds);
        drain_unit();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(seconds);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        window_writes++;
    endtask

    // Mostly modest rates, some wide enough to saturate a block mean,
    // some full 24-bit patterns and the two rails
    function automatic logic signed [CLIMB_W-1:0] random_climb();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1: return CLIMB_W'($urandom);
            2: return $urandom_range(0, 1) ? CLIMB_W'(8388607) : CLIMB_W'(-8388608);
            3, 4: return CLIMB_W'(int'($urandom_range(0, 200000)) - 100000);
            default: return CLIMB_W'(int'($urandom_range(0, 60000)) - 30000);
        endcase
    endfunction

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        i_in_valid       = 1'b0;
        i_climb_cms      = '0;
        i_restart        = 1'b0;
        quiet_phase      = 1'b0;
        holdoff_requests = 0;
        holdoffs_served  = 0;
        samples_sent     = 0;
        restarts_sent    = 0;
        window_writes    = 0;

        // hold reset while the clock runs, then release it between edges
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Window off after reset: every sample passes straight through,
        // while the history still takes saturated block means of both signs.
        send_sample(CLIMB_W'(8388607), 1'b0);
        send_sample(CLIMB_W'(8388607), 1'b0);
        send_sample(CLIMB_W'(-8388608), 1'b0);
        send_sample(CLIMB_W'(-8388608), 1'b0);

        // A value above the maximum clamps to the longest window
        write_window(7);
        // restart empties the history, so this sample passes through
        send_sample(CLIMB_W'(5), 1'b0 | 1'b1);
        // block mean of -3/2 truncates toward zero
        send_sample(CLIMB_W'(-8), 1'b0);
        // window longer than the history: only the held entries are averaged
        send_sample(CLIMB_W'(8388607), 1'b0);
        send_sample(CLIMB_W'(8388607), 1'b0);
        send_sample(CLIMB_W'(-8388608), 1'b0);
        send_sample(CLIMB_W'(-8388608), 1'b0);
        send_sample(CLIMB_W'(0), 1'b0);
        send_sample(CLIMB_W'(-1), 1'b0);
        // alternating bit patterns over the full field
        send_sample(CLIMB_W'(24'h555555), 1'b0);
        send_sample(CLIMB_W'(24'hAAAAAA), 1'b0);
        // restart with half a block accumulated
        send_sample(CLIMB_W'(9), 1'b0);
        send_sample(CLIMB_W'(7), 1'b1);
        send_sample(CLIMB_W'(-7), 1'b0);

        // Shortest nonzero window, still longer than the history held since the restart
        write_window(1);
        send_sample(CLIMB_W'(100), 1'b0);
        send_sample(CLIMB_W'(-300), 1'b0);

        // Back to pass-through with a non-empty history
        write_window(0);
        send_sample(CLIMB_W'(42), 1'b0);

        // Random phases, one window setting each; restarts are rare so the
        // history fills, wraps and hits its cap along the way.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_window(phase_windows[p]);
            quiet_phase = (p == PHASE_COUNT - 1);
            for (int k = 0; k < PHASE_SAMPLES; k++) begin
                // back up the result side while samples keep coming
                if (p == 1 && k == 20) holdoff_requests++;
                // pause the sender until every display value is back
                if (p == 3 && k == 30) drain_unit();
                send_sample(random_climb(), $urandom_range(0, 99) == 0);
            end
        end

        drain_unit();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d samples (%0d restarts), %0d window writes, %0d results compared.",
                 samples_sent, restarts_sent, window_writes, checked);
        if (errors == 0 && pending == 0) begin
            $display("climb_display_window_average_unit verification clean");
        end else begin
            $display("climb_display_window_average_unit verification failed");
        end
        $finish;
    end

endmodule

### sim.f
src/cdwa_pkg.sv
src/cdwa_div.sv
src/climb_display_window_average_unit.sv
tb/sv/cdwa_display_check.sv
tb/sv/tb.sv
